[sv/obfa_pkg.sv]
// ============================================================================
// obfa_pkg
// Shared widths, axis codes and per-step arithmetic for the orthonormal
// basis pipeline.
// ============================================================================
package obfa_pkg;

    localparam int IN_W       = 16;
    localparam int FRAC_BITS  = 14;
    localparam int OUT_W      = FRAC_BITS + 2;
    localparam int AX_W       = 2;
    localparam int NUM_LANES  = 6;

    localparam int MAG_W      = IN_W;
    localparam int SQ_W       = 2 * IN_W - 1;
    localparam int P_W        = SQ_W + 1;
    localparam int NUM_W      = 2 * SQ_W - 1;
    localparam int DEN_W      = 2 * P_W - 1;

    // quotient of num * 2^(2F+2) / den, at most 2^(2F+2)
    localparam int QUO_W      = 2 * FRAC_BITS + 3;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = (QUO_W + 1) / 2;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int LANE_LAT   = DIV_STEPS + SQRT_STEPS;

    typedef logic [AX_W-1:0] t_axis;
    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    typedef struct packed {
        logic                 deg;
        t_axis                axis;
        logic [NUM_LANES-1:0] neg;
    } t_side;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic             qbit;
    } t_div;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic              rbit;
    } t_sqrt;

    function automatic t_div div_step(input logic [DEN_W:0] t,
                                      input logic [DEN_W-1:0] d);
        logic [DEN_W:0] diff;
        t_div           r;
        diff   = t - {1'b0, d};
        r.qbit = (t >= {1'b0, d});
        r.rem  = r.qbit ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        return r;
    endfunction

    function automatic t_sqrt sqrt_step(input logic [SREM_W-1:0] rem,
                                        input logic [1:0]        pair,
                                        input logic [ROOT_W-1:0] root);
        logic [SREM_W+1:0] t;
        logic [SREM_W+1:0] trial;
        logic [SREM_W+1:0] diff;
        t_sqrt             r;
        t      = {rem, pair};
        trial  = {2'b00, root, 2'b01};
        diff   = t - trial;
        r.rbit = (t >= trial);
        r.rem  = r.rbit ? diff[SREM_W-1:0] : t[SREM_W-1:0];
        return r;
    endfunction

endpackage

[sv/obfa_lane.sv]
// ============================================================================
// obfa_lane
// One component lane: pipelined restoring division giving
// floor(num * 2^(2F+2) / den), then a pipelined digit-by-digit square root.
// ============================================================================
module obfa_lane (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [obfa_pkg::NUM_W-1:0]        i_num,
    input  logic [obfa_pkg::DEN_W-1:0]        i_den,
    output logic [obfa_pkg::ROOT_W-1:0]       o_root
);

    localparam int DS = obfa_pkg::DIV_STEPS;
    localparam int SS = obfa_pkg::SQRT_STEPS;

    logic [obfa_pkg::DEN_W-1:0]  r_rem  [1:DS-1];
    logic [obfa_pkg::DEN_W-1:0]  r_den  [1:DS-1];
    logic [obfa_pkg::QUO_W-1:0]  r_quo  [1:DS];
    logic [obfa_pkg::RAD_W-1:0]  r_srad [1:SS-1];
    logic [obfa_pkg::SREM_W-1:0] r_srem [1:SS-1];
    logic [obfa_pkg::ROOT_W-1:0] r_root [1:SS];

    genvar j;
    generate
        for (j = 0; j < DS; j++) begin : g_div
            logic [obfa_pkg::DEN_W:0]   t;
            logic [obfa_pkg::DEN_W-1:0] d;
            logic [obfa_pkg::QUO_W-1:0] q;
            obfa_pkg::t_div             s;
            if (j == 0) begin : g_first
                // {num >> 1, num[0]} is num itself
                assign t = (obfa_pkg::DEN_W + 1)'(i_num);
                assign d = i_den;
                assign q = '0;
            end else begin : g_next
                assign t = {r_rem[j], 1'b0};
                assign d = r_den[j];
                assign q = r_quo[j];
            end
            assign s = obfa_pkg::div_step(t, d);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[j+1] <= {q[obfa_pkg::QUO_W-2:0], s.qbit};
                end
            end
            if (j < DS - 1) begin : g_den
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[j+1] <= s.rem;
                        r_den[j+1] <= d;
                    end
                end
            end
        end

        for (j = 0; j < SS; j++) begin : g_sqrt
            logic [obfa_pkg::RAD_W-1:0]  rad;
            logic [obfa_pkg::SREM_W-1:0] rem;
            logic [obfa_pkg::ROOT_W-1:0] root;
            obfa_pkg::t_sqrt             s;
            if (j == 0) begin : g_first
                assign rad  = obfa_pkg::RAD_W'(r_quo[DS]);
                assign rem  = '0;
                assign root = '0;
            end else begin : g_next
                assign rad  = r_srad[j];
                assign rem  = r_srem[j];
                assign root = r_root[j];
            end
            assign s = obfa_pkg::sqrt_step(rem, rad[obfa_pkg::RAD_W-1 -: 2], root);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_root[j+1] <= {root[obfa_pkg::ROOT_W-2:0], s.rbit};
                end
            end
            if (j < SS - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_srad[j+1] <= {rad[obfa_pkg::RAD_W-3:0], 2'b00};
                        r_srem[j+1] <= s.rem;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[SS];

endmodule

[sv/orthonormal_basis_from_axis.sv]
// ============================================================================
// orthonormal_basis_from_axis
// Completes an orthonormal frame from one direction vector; results in Q2.14.
// ============================================================================
//  channel  | signals                          | dir
//  ---------+----------------------------------+-----
//  input    | i_valid, o_stall, i_z_x/y/z      | in
//  output   | o_valid, i_stall, o_x_*, o_y_*,  | out
//           | o_axis_used, o_degenerate        |
//
//  One transfer per cycle unless a held result stalls the pipeline; 3 setup
//  stages, 31 divide steps and 16 square-root steps per lane, 1 output register.
//  Reset clears only the stage valid bits.
//  A stalled result freezes the whole pipeline; o_stall is high only while
//  a result is held.
module orthonormal_basis_from_axis (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [obfa_pkg::IN_W-1:0]    i_z_x,
    input  logic signed [obfa_pkg::IN_W-1:0]    i_z_y,
    input  logic signed [obfa_pkg::IN_W-1:0]    i_z_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [obfa_pkg::OUT_W-1:0]   o_x_x,
    output logic signed [obfa_pkg::OUT_W-1:0]   o_x_y,
    output logic signed [obfa_pkg::OUT_W-1:0]   o_x_z,
    output logic signed [obfa_pkg::OUT_W-1:0]   o_y_x,
    output logic signed [obfa_pkg::OUT_W-1:0]   o_y_y,
    output logic signed [obfa_pkg::OUT_W-1:0]   o_y_z,
    output logic [obfa_pkg::AX_W-1:0]           o_axis_used,
    output logic                                o_degenerate
);

    localparam int LAT = obfa_pkg::LANE_LAT;
    localparam int NL  = obfa_pkg::NUM_LANES;

    logic en;

    // ---- stage A: magnitudes and squares
    logic [obfa_pkg::IN_W-1:0]   z_in   [3];
    logic [obfa_pkg::IN_W:0]     z_ext  [3];
    logic [obfa_pkg::IN_W:0]     z_neg  [3];
    logic [2*obfa_pkg::IN_W-1:0] sq_full[3];
    logic [obfa_pkg::MAG_W-1:0]  n_a_mag[3];
    logic                        r_a_v;
    logic [obfa_pkg::MAG_W-1:0]  r_a_mag[3];
    logic [obfa_pkg::SQ_W-1:0]   r_a_sq [3];
    logic                        r_a_sgn[3];

    // ---- stage B: axis, norms, lane numerators
    logic                        r_b_v;
    obfa_pkg::t_side             n_b_sd, r_b_sd;
    logic [obfa_pkg::P_W-1:0]    n_b_p, r_b_p, n_b_n, r_b_n;
    logic [obfa_pkg::SQ_W-1:0]   n_b_sqk, r_b_sqk;
    logic [obfa_pkg::SQ_W-1:0]   n_b_xn [3];
    logic [obfa_pkg::SQ_W-1:0]   r_b_xn [3];
    logic [obfa_pkg::SQ_W-1:0]   r_b_sq [3];

    // ---- stage C and lanes
    logic [2*obfa_pkg::SQ_W-1:0] prod_y [3];
    logic [2*obfa_pkg::P_W-1:0]  prod_np;
    logic [obfa_pkg::NUM_W-1:0]  r_c_num[NL];
    logic [obfa_pkg::DEN_W-1:0]  r_c_den[NL];
    logic                        r_pv   [0:LAT];
    obfa_pkg::t_side             r_sd   [0:LAT];
    logic [obfa_pkg::ROOT_W-1:0] root   [NL];
    logic [obfa_pkg::ROOT_W:0]   root_p1[NL];
    logic [obfa_pkg::OUT_W-1:0]  n_res  [NL];

    // ---- output register
    logic                        r_out_v;
    logic [obfa_pkg::OUT_W-1:0]  r_res  [NL];
    logic [obfa_pkg::AX_W-1:0]   r_axis;
    logic                        r_deg;

    assign en      = !(r_out_v && i_stall);
    assign o_stall = r_out_v && i_stall;

    assign z_in[0] = i_z_x;
    assign z_in[1] = i_z_y;
    assign z_in[2] = i_z_z;

    always_comb begin
        for (int m = 0; m < 3; m++) begin
            z_ext[m]   = {z_in[m][obfa_pkg::IN_W-1], z_in[m]};
            z_neg[m]   = -z_ext[m];
            n_a_mag[m] = z_in[m][obfa_pkg::IN_W-1] ? z_neg[m][obfa_pkg::IN_W-1:0]
                                                   : z_ext[m][obfa_pkg::IN_W-1:0];
            sq_full[m] = (2*obfa_pkg::IN_W)'(n_a_mag[m]) * (2*obfa_pkg::IN_W)'(n_a_mag[m]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < 3; m++) begin
                r_a_mag[m] <= n_a_mag[m];
                r_a_sq[m]  <= sq_full[m][obfa_pkg::SQ_W-1:0];
                r_a_sgn[m] <= z_in[m][obfa_pkg::IN_W-1];
            end
        end
    end

    always_comb begin
        n_b_sd.deg = (r_a_mag[0] == '0) && (r_a_mag[1] == '0) && (r_a_mag[2] == '0);
        if (r_a_mag[0] <= r_a_mag[1] && r_a_mag[0] <= r_a_mag[2]) begin
            n_b_sd.axis = obfa_pkg::AXIS_X;
        end else if (r_a_mag[1] <= r_a_mag[2]) begin
            n_b_sd.axis = obfa_pkg::AXIS_Y;
        end else begin
            n_b_sd.axis = obfa_pkg::AXIS_Z;
        end
        n_b_n = obfa_pkg::P_W'(r_a_sq[0]) + obfa_pkg::P_W'(r_a_sq[1])
              + obfa_pkg::P_W'(r_a_sq[2]);
        n_b_sd.neg = '0;
        case (n_b_sd.axis)
            obfa_pkg::AXIS_X: begin
                n_b_sqk      = r_a_sq[0];
                n_b_p        = obfa_pkg::P_W'(r_a_sq[1]) + obfa_pkg::P_W'(r_a_sq[2]);
                n_b_xn[0]    = '0;
                n_b_xn[1]    = r_a_sq[2];
                n_b_xn[2]    = r_a_sq[1];
                n_b_sd.neg[1] = r_a_sgn[2];
                n_b_sd.neg[2] = !r_a_sgn[1];
                n_b_sd.neg[3] = 1'b1;
                n_b_sd.neg[4] = r_a_sgn[0] ^ r_a_sgn[1];
                n_b_sd.neg[5] = r_a_sgn[0] ^ r_a_sgn[2];
            end
            obfa_pkg::AXIS_Y: begin
                n_b_sqk      = r_a_sq[1];
                n_b_p        = obfa_pkg::P_W'(r_a_sq[0]) + obfa_pkg::P_W'(r_a_sq[2]);
                n_b_xn[0]    = r_a_sq[2];
                n_b_xn[1]    = '0;
                n_b_xn[2]    = r_a_sq[0];
                n_b_sd.neg[0] = !r_a_sgn[2];
                n_b_sd.neg[2] = r_a_sgn[0];
                n_b_sd.neg[3] = r_a_sgn[1] ^ r_a_sgn[0];
                n_b_sd.neg[4] = 1'b1;
                n_b_sd.neg[5] = r_a_sgn[1] ^ r_a_sgn[2];
            end
            default: begin
                n_b_sqk      = r_a_sq[2];
                n_b_p        = obfa_pkg::P_W'(r_a_sq[0]) + obfa_pkg::P_W'(r_a_sq[1]);
                n_b_xn[0]    = r_a_sq[1];
                n_b_xn[1]    = r_a_sq[0];
                n_b_xn[2]    = '0;
                n_b_sd.neg[0] = r_a_sgn[1];
                n_b_sd.neg[1] = !r_a_sgn[0];
                n_b_sd.neg[3] = r_a_sgn[2] ^ r_a_sgn[0];
                n_b_sd.neg[4] = r_a_sgn[2] ^ r_a_sgn[1];
                n_b_sd.neg[5] = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sd  <= n_b_sd;
            r_b_p   <= n_b_p;
            r_b_n   <= n_b_n;
            r_b_sqk <= n_b_sqk;
            for (int m = 0; m < 3; m++) begin
                r_b_xn[m] <= n_b_xn[m];
                r_b_sq[m] <= r_a_sq[m];
            end
        end
    end

    always_comb begin
        prod_np = (2*obfa_pkg::P_W)'(r_b_n) * (2*obfa_pkg::P_W)'(r_b_p);
        for (int m = 0; m < 3; m++) begin
            prod_y[m] = (2*obfa_pkg::SQ_W)'(r_b_sqk) * (2*obfa_pkg::SQ_W)'(r_b_sq[m]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_b_sd;
            for (int m = 0; m < 3; m++) begin
                r_c_num[m] <= obfa_pkg::NUM_W'(r_b_xn[m]);
                r_c_den[m] <= obfa_pkg::DEN_W'(r_b_p);
                if (r_b_sd.axis == obfa_pkg::AX_W'(m)) begin
                    r_c_num[3+m] <= obfa_pkg::NUM_W'(r_b_p);
                    r_c_den[3+m] <= obfa_pkg::DEN_W'(r_b_n);
                end else begin
                    r_c_num[3+m] <= prod_y[m][obfa_pkg::NUM_W-1:0];
                    r_c_den[3+m] <= prod_np[obfa_pkg::DEN_W-1:0];
                end
            end
            for (int s = 1; s <= LAT; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
        end
    end

    genvar l;
    generate
        for (l = 0; l < NL; l++) begin : g_lane
            obfa_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_num  (r_c_num[l]),
                .i_den  (r_c_den[l]),
                .o_root (root[l])
            );
        end
    endgenerate

    // round(2^F * sqrt(ratio)) = (isqrt(4^(F+1) * ratio) + 1) / 2
    always_comb begin
        for (int m = 0; m < NL; m++) begin
            root_p1[m] = {1'b0, root[m]} + 1'b1;
            if (r_sd[LAT].deg) begin
                n_res[m] = '0;
            end else if (r_sd[LAT].neg[m]) begin
                n_res[m] = -root_p1[m][obfa_pkg::ROOT_W:1];
            end else begin
                n_res[m] = root_p1[m][obfa_pkg::ROOT_W:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < NL; m++) begin
                r_res[m] <= n_res[m];
            end
            r_axis <= r_sd[LAT].deg ? obfa_pkg::AXIS_X : r_sd[LAT].axis;
            r_deg  <= r_sd[LAT].deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
            for (int s = 0; s <= LAT; s++) begin
                r_pv[s] <= 1'b0;
            end
        end else if (en) begin
            r_a_v   <= i_valid;
            r_b_v   <= r_a_v;
            r_pv[0] <= r_b_v;
            for (int s = 1; s <= LAT; s++) begin
                r_pv[s] <= r_pv[s-1];
            end
            r_out_v <= r_pv[LAT];
        end
    end

    assign o_valid      = r_out_v;
    assign o_x_x        = r_res[0];
    assign o_x_y        = r_res[1];
    assign o_x_z        = r_res[2];
    assign o_y_x        = r_res[3];
    assign o_y_y        = r_res[4];
    assign o_y_z        = r_res[5];
    assign o_axis_used  = r_axis;
    assign o_degenerate = r_deg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result held");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_x_x == 0 && o_x_y == 0 && o_x_z == 0 &&
        o_y_x == 0 && o_y_y == 0 && o_y_z == 0 && o_axis_used == obfa_pkg::AXIS_X)
        else $error("degenerate result not zero");

    a_axis_component: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate && o_axis_used == obfa_pkg::AXIS_X |->
        o_x_x == 0 && o_y_x <= 0)
        else $error("x-axis components wrong");

    a_axis_component_yz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate && o_axis_used != obfa_pkg::AXIS_X |->
        (o_axis_used == obfa_pkg::AXIS_Y && o_x_y == 0 && o_y_y <= 0) ||
        (o_axis_used == obfa_pkg::AXIS_Z && o_x_z == 0 && o_y_z <= 0))
        else $error("y/z-axis components wrong");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_x_x <= 16384 && o_x_x >= -16384 &&
        o_y_y <= 16384 && o_y_y >= -16384)
        else $error("component out of unit range");
`endif

endmodule

[tb/orthonormal_basis_from_axis_checker.sv]
// ============================================================================
// orthonormal_basis_from_axis_checker
// Watches both channels of the basis pipeline. It predicts each frame from
// the accepted direction vector in exact integer arithmetic and compares the
// results in order, one field at a time.
// ============================================================================
module orthonormal_basis_from_axis_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic signed [obfa_pkg::IN_W-1:0]    i_z_x,
    input  logic signed [obfa_pkg::IN_W-1:0]    i_z_y,
    input  logic signed [obfa_pkg::IN_W-1:0]    i_z_z,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic signed [obfa_pkg::OUT_W-1:0]   o_x_x,
    input  logic signed [obfa_pkg::OUT_W-1:0]   o_x_y,
    input  logic signed [obfa_pkg::OUT_W-1:0]   o_x_z,
    input  logic signed [obfa_pkg::OUT_W-1:0]   o_y_x,
    input  logic signed [obfa_pkg::OUT_W-1:0]   o_y_y,
    input  logic signed [obfa_pkg::OUT_W-1:0]   o_y_z,
    input  logic [obfa_pkg::AX_W-1:0]           o_axis_used,
    input  logic                                o_degenerate,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_frames,
    output int                                  o_degenerate_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [obfa_pkg::OUT_W-1:0] comp [6];
        obfa_pkg::t_axis                   axis;
        logic                              deg;
    } t_frame;

    t_frame frame_q [$];

    // round(2^F * sqrt(n1*n2 / (d1*d2))), magnitude tie away from zero
    function automatic logic [obfa_pkg::OUT_W-1:0] unit_ratio(
        logic [127:0] n1, logic [127:0] n2, logic [127:0] d1, logic [127:0] d2);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        logic [127:0] odd;
        logic [127:0] rhs;
        lo  = 0;
        hi  = 128'd1 << obfa_pkg::FRAC_BITS;
        rhs = (n1 * n2) << (2 * obfa_pkg::FRAC_BITS + 2);
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 2 * mid - 1;
            if (odd * odd * d1 * d2 <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo[obfa_pkg::OUT_W-1:0];
    endfunction

    function automatic logic signed [obfa_pkg::OUT_W-1:0] apply_sign(
        logic [obfa_pkg::OUT_W-1:0] q, logic neg);
        return neg ? -q : q;
    endfunction

    function automatic t_frame basis_frame(logic signed [obfa_pkg::IN_W-1:0] zx,
                                           logic signed [obfa_pkg::IN_W-1:0] zy,
                                           logic signed [obfa_pkg::IN_W-1:0] zz);
        t_frame       f;
        longint       z [3];
        longint       xr [3];
        logic [127:0] a [3];
        logic [127:0] sq [3];
        logic [127:0] p;
        logic [127:0] n;
        logic [127:0] xm;
        int           k;
        z[0] = zx; z[1] = zy; z[2] = zz;
        for (int m = 0; m < 3; m++) begin
            a[m]  = (z[m] < 0) ? -z[m] : z[m];
            sq[m] = a[m] * a[m];
        end
        for (int m = 0; m < 6; m++) f.comp[m] = '0;
        f.axis = obfa_pkg::AXIS_X;
        f.deg  = 1'b0;
        if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
            f.deg = 1'b1;
            return f;
        end
        if (a[0] <= a[1] && a[0] <= a[2]) k = 0;
        else if (a[1] <= a[2]) k = 1;
        else k = 2;
        case (k)
            0: begin
                xr[0] = 0; xr[1] = z[2]; xr[2] = -z[1]; f.axis = obfa_pkg::AXIS_X;
            end
            1: begin
                xr[0] = -z[2]; xr[1] = 0; xr[2] = z[0]; f.axis = obfa_pkg::AXIS_Y;
            end
            default: begin
                xr[0] = z[1]; xr[1] = -z[0]; xr[2] = 0; f.axis = obfa_pkg::AXIS_Z;
            end
        endcase
        p = 0;
        for (int m = 0; m < 3; m++) if (m != k) p += sq[m];
        n = p + sq[k];
        for (int m = 0; m < 3; m++) begin
            xm = (xr[m] < 0) ? -xr[m] : xr[m];
            f.comp[m] = apply_sign(unit_ratio(xm * xm, 1, p, 1), xr[m] < 0);
            if (m == k)
                f.comp[3+m] = apply_sign(unit_ratio(p, 1, n, 1), 1'b1);
            else
                f.comp[3+m] = apply_sign(unit_ratio(sq[k], sq[m], n, p),
                                         (z[k] < 0) != (z[m] < 0));
        end
        return f;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_frames = 0;
        o_degenerate_seen = 0;
    end

    always @(posedge i_clk) begin
        t_frame                            want;
        logic signed [obfa_pkg::OUT_W-1:0] got [6];
        bit                                bad;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                frame_q.push_back(basis_frame(i_z_x, i_z_y, i_z_z));
            if (o_valid && !i_stall) begin
                got[0] = o_x_x; got[1] = o_x_y; got[2] = o_x_z;
                got[3] = o_y_x; got[4] = o_y_y; got[5] = o_y_z;
                o_frames++;
                if (o_degenerate) o_degenerate_seen++;
                if (frame_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("[%0t] unexpected result transfer", $realtime);
                end else begin
                    want = frame_q.pop_front();
                    bad = (o_axis_used !== want.axis) || (o_degenerate !== want.deg);
                    for (int m = 0; m < 6; m++) if (got[m] !== want.comp[m]) bad = 1;
                    if (bad) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"[%0t] mismatch exp x=(%0d %0d %0d) ",
                                      "y=(%0d %0d %0d) ax=%0d dg=%0d ",
                                      "got x=(%0d %0d %0d) y=(%0d %0d %0d) ",
                                      "ax=%0d dg=%0d"},
                                $realtime, want.comp[0], want.comp[1], want.comp[2],
                                want.comp[3], want.comp[4], want.comp[5],
                                want.axis, want.deg,
                                got[0], got[1], got[2], got[3], got[4], got[5],
                                o_axis_used, o_degenerate);
                    end
                end
            end
        end
        o_pending = frame_q.size();
    end
endmodule

[tb/orthonormal_basis_from_axis_test.sv]
// ============================================================================
// orthonormal_basis_from_axis_test
// Drives direction vectors into the basis pipeline with random gaps and
// result back-pressure, including a long output hold-off and a full drain,
// and reports the checker's verdict.
// ============================================================================
module orthonormal_basis_from_axis_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 430;
    localparam int QUIET_TAIL   = 50;
    localparam int HOLD_CYCLES  = 200;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic signed [obfa_pkg::IN_W-1:0]  i_z_x, i_z_y, i_z_z;
    logic                              o_valid;
    logic                              i_stall;
    logic signed [obfa_pkg::OUT_W-1:0] o_x_x, o_x_y, o_x_z, o_y_x, o_y_y, o_y_z;
    logic [obfa_pkg::AX_W-1:0]         o_axis_used;
    logic                              o_degenerate;
    int                                errors, pending, frames, degenerate_seen;
    bit                                quiet;
    bit                                hold_req;
    int                                sent;

    orthonormal_basis_from_axis dut (.*);

    orthonormal_basis_from_axis_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_z_x, .i_z_y, .i_z_z,
        .o_valid, .i_stall, .o_x_x, .o_x_y, .o_x_z, .o_y_x, .o_y_y, .o_y_z,
        .o_axis_used, .o_degenerate,
        .o_errors(errors), .o_pending(pending), .o_frames(frames),
        .o_degenerate_seen(degenerate_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    // result side back-pressure
    initial begin
        int burst;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 10);
                i_stall <= 1'b1;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_vector(logic signed [obfa_pkg::IN_W-1:0] x,
                               logic signed [obfa_pkg::IN_W-1:0] y,
                               logic signed [obfa_pkg::IN_W-1:0] z);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_z_x   <= x;
        i_z_y   <= y;
        i_z_z   <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [obfa_pkg::IN_W-1:0] rand_comp(int style);
        case (style)
            0: return obfa_pkg::IN_W'($urandom);
            1: return obfa_pkg::IN_W'(signed'($urandom_range(0, 15)) - 8);
            2: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
            default: return obfa_pkg::IN_W'(signed'($urandom_range(0, 511)) - 256);
        endcase
    endfunction

    initial begin
        logic signed [obfa_pkg::IN_W-1:0] v [3];
        int style;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_z_x = '0; i_z_y = '0; i_z_z = '0;
        quiet = 0; hold_req = 0; sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero, extremes, ties, single-axis vectors
        send_vector(0, 0, 0);
        send_vector(-32768, -32768, -32768);
        send_vector(32767, 32767, 32767);
        send_vector(-32768, 32767, 0);
        send_vector(1, 1, 1);
        send_vector(-1, -1, -1);
        send_vector(5, 5, 9);
        send_vector(9, 5, 5);
        send_vector(9, 5, 9);
        send_vector(7, -7, 7);
        send_vector(1, 0, 0);
        send_vector(0, -1, 0);
        send_vector(0, 0, -32768);
        send_vector(32767, 0, 0);
        send_vector(100, -3, 200);
        send_vector(-300, 200, 2);
        send_vector(-3, 2, -32768);
        send_vector(0, 0, 0);
        send_vector(12345, -23456, 30000);
        send_vector(-1, 32767, -32768);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 120) hold_req = 1;
            if (i == 260) begin
                i_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            if (i == RANDOM_ITEMS - QUIET_TAIL) quiet = 1;
            style = $urandom_range(0, 3);
            for (int m = 0; m < 3; m++) v[m] = rand_comp(style);
            case ($urandom_range(0, 9))
                0: v[$urandom_range(0, 2)] = 0;
                1: v[1] = v[0];
                2: v[2] = -v[1];
                3: begin v[0] = 0; v[1] = 0; v[2] = 0; end
                default: ;
            endcase
            send_vector(v[0], v[1], v[2]);
        end
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("%0d vectors sent, %0d frames checked (%0d zero-vector cases)",
                 sent, frames, degenerate_seen);
        $display("covered extremes, axis ties, long output hold-off and full drain");
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule

[files.f]
sv/obfa_pkg.sv
sv/obfa_lane.sv
sv/orthonormal_basis_from_axis.sv
tb/orthonormal_basis_from_axis_checker.sv
tb/orthonormal_basis_from_axis_test.sv
